[hw/rtl/pta_pkg.sv]
// Package for the primitive-to-triangle assembler: vertex and job types,
// primitive kind codes, job op codes and queue sizing. No dependencies.
`timescale 1ns / 1ps

package pta_pkg;

    localparam int WORD_W      = 32;
    localparam int KIND_W      = 3;
    localparam int POS_W       = 2;
    localparam int OP_W        = 3;
    localparam int STEP_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Primitive kinds as they arrive on primitive_kind
    localparam logic [KIND_W-1:0] KIND_TRIANGLES = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STRIP     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FAN       = 3'd5;
    localparam logic [KIND_W-1:0] KIND_QUADS     = 3'd6;

    // Job op codes passed from the front end to the back end
    localparam logic [OP_W-1:0] OP_HOLD  = 3'd0;
    localparam logic [OP_W-1:0] OP_TRI   = 3'd1;
    localparam logic [OP_W-1:0] OP_STRIP = 3'd2;
    localparam logic [OP_W-1:0] OP_FAN   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUAD  = 3'd4;

    // Held vertex slot numbers
    localparam logic [POS_W-1:0] SLOT_0 = 2'd0;
    localparam logic [POS_W-1:0] SLOT_1 = 2'd1;
    localparam logic [POS_W-1:0] SLOT_2 = 2'd2;

    // Last sequencer step of a strip/fan triangle and of a quad pair
    localparam logic [STEP_W-1:0] STEP_TRI_LAST  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_QUAD_LAST = 3'd5;

    typedef struct packed {
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] color;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] slot;
        vertex_t          vtx;
    } job_t;

endpackage

[hw/rtl/pta_front.sv]
// Front end: accepts vertices, tracks draw kind and position in the draw,
// and turns each vertex into a job (or drops it). Depends on pta_pkg.
`timescale 1ns / 1ps

module pta_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pta_pkg::vertex_t      in_vtx,
    input  logic [2:0]            primitive_kind,
    input  logic                  first_of_draw,
    output logic                  push,
    output pta_pkg::job_t         push_job,
    input  logic                  queue_full
);
    import pta_pkg::*;

    logic [KIND_W-1:0] draw_kind_reg, draw_kind_next;
    logic [POS_W-1:0]  vpos_reg, vpos_next;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic              accept;
    logic              emit_job;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        kind            = first_of_draw ? primitive_kind : draw_kind_reg;
        pos             = first_of_draw ? '0 : vpos_reg;
        emit_job        = 1'b0;
        push_job.op     = OP_TRI;
        push_job.slot   = pos;
        push_job.vtx    = in_vtx;
        draw_kind_next  = draw_kind_reg;
        vpos_next       = vpos_reg;
        if (accept)
        begin
            draw_kind_next = kind;
            vpos_next      = pos;
            case (kind)
                KIND_TRIANGLES:
                begin
                    emit_job    = 1'b1;
                    push_job.op = OP_TRI;
                end
                KIND_STRIP, KIND_FAN:
                begin
                    emit_job = 1'b1;
                    if (pos < 2'd2)
                    begin
                        push_job.op = OP_HOLD;
                        vpos_next   = pos + 2'd1;
                    end
                    else
                    begin
                        push_job.op = (kind == KIND_STRIP) ? OP_STRIP : OP_FAN;
                    end
                end
                KIND_QUADS:
                begin
                    emit_job = 1'b1;
                    if (pos < 2'd3)
                    begin
                        push_job.op = OP_HOLD;
                        vpos_next   = pos + 2'd1;
                    end
                    else
                    begin
                        push_job.op = OP_QUAD;
                        vpos_next   = '0;
                    end
                end
                default:
                begin
                    emit_job = 1'b0;  // points, lines, unused kind: dropped
                end
            endcase
        end
    end

    assign push = emit_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_kind_reg <= '0;
            vpos_reg      <= '0;
        end
        else
        begin
            draw_kind_reg <= draw_kind_next;
            vpos_reg      <= vpos_next;
        end
    end

endmodule

[hw/rtl/pta_queue.sv]
// Short job queue between front and back end. Depends on pta_pkg.
`timescale 1ns / 1ps

module pta_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pta_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pta_pkg::job_t head_job
);
    import pta_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/pta_back.sv]
// Back end: holds up to three vertices, sequences each job's vertices into
// an output register, one per cycle unless stalled. Depends on pta_pkg.
`timescale 1ns / 1ps

module pta_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  pta_pkg::job_t    head_job,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output pta_pkg::vertex_t out_vtx,
    output logic             out_last
);
    import pta_pkg::*;

    vertex_t           slot0_reg, slot1_reg, slot2_reg;
    vertex_t           slot0_next, slot1_next, slot2_next;
    vertex_t           out_vtx_reg, out_vtx_next;
    logic              out_last_reg, out_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_load;
    logic              emit;
    logic              last;
    vertex_t           sel;

    assign out_load = !out_valid_reg || out_ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        slot2_next = slot2_reg;
        emit       = 1'b0;
        last       = 1'b0;
        pop        = 1'b0;
        sel        = head_job.vtx;
        if (head_valid)
        begin
            case (head_job.op)
                OP_HOLD:
                begin
                    pop = 1'b1;
                    case (head_job.slot)
                        SLOT_0:  slot0_next = head_job.vtx;
                        SLOT_1:  slot1_next = head_job.vtx;
                        SLOT_2:  slot2_next = head_job.vtx;
                        default: slot2_next = slot2_reg;
                    endcase
                end
                OP_TRI:
                begin
                    emit = out_load;
                    last = 1'b1;
                end
                OP_STRIP, OP_FAN:
                begin
                    emit = out_load;
                    last = (step_reg == STEP_TRI_LAST);
                    case (step_reg)
                        3'd0:    sel = slot0_reg;
                        3'd1:    sel = slot1_reg;
                        default: sel = head_job.vtx;
                    endcase
                    if (emit && last)
                    begin
                        if (head_job.op == OP_STRIP)
                            slot0_next = slot1_reg;
                        slot1_next = head_job.vtx;
                    end
                end
                OP_QUAD:
                begin
                    emit = out_load;
                    last = (step_reg == STEP_QUAD_LAST);
                    case (step_reg)
                        3'd0:    sel = slot0_reg;
                        3'd1:    sel = slot1_reg;
                        3'd2:    sel = slot2_reg;
                        3'd3:    sel = slot1_reg;
                        3'd4:    sel = slot2_reg;
                        default: sel = head_job.vtx;
                    endcase
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
            if (emit && last)
                pop = 1'b1;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (emit)
            step_next = last ? '0 : step_reg + 3'd1;
        out_vtx_next   = out_vtx_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = emit;
            out_vtx_next   = sel;
            out_last_next  = last;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg   <= slot0_next;
        slot1_reg   <= slot1_next;
        slot2_reg   <= slot2_next;
        out_vtx_reg <= out_vtx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vtx   = out_vtx_reg;
    assign out_last  = out_last_reg;

endmodule

[hw/rtl/primitive_to_triangle_assembler.sv]
// Top level of the primitive-to-triangle assembler: front end, job queue,
// back end. Depends on pta_pkg, pta_front, pta_queue, pta_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one vertex per transaction, five raw
//   words plus primitive_kind and first_of_draw. first_of_draw latches the
//   kind and restarts assembly; kind is ignored on other vertices.
//   Output channel (out_valid/out_ready): one triangle-list vertex per
//   transaction; last_of_run marks the final vertex caused by an input.
//   Triangles pass one vertex through, strips and fans emit three vertices
//   per vertex from the third on, a complete quad emits six. Points, lines,
//   line strips and kind 7 are dropped, as are vertices before any draw.
// Timing:
//   The first output vertex passes through the job queue and the output
//   register. The back end emits one vertex per cycle unless out_ready stalls
//   it; a held vertex also takes its turn in the back end, without output.
//   A two-entry job queue lets the input side keep accepting while the
//   back end is busy; in_ready drops only when that queue is full.
// Reset: rst_n clears draw kind, draw position, queue and output valid.
// Stall: while out_ready is low a valid vertex stays in the output register,
//   emit jobs wait, and the queue fills, after which in_ready goes low.
`timescale 1ns / 1ps

module primitive_to_triangle_assembler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] color_word,
    input  logic [31:0] tex_u,
    input  logic [31:0] tex_v,
    input  logic [2:0]  primitive_kind,
    input  logic        first_of_draw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_pos_x,
    output logic [31:0] out_pos_y,
    output logic [31:0] out_color,
    output logic [31:0] out_tex_u,
    output logic [31:0] out_tex_v,
    output logic        last_of_run
);
    import pta_pkg::*;

    vertex_t in_vtx;
    vertex_t out_vtx;
    job_t    push_job;
    job_t    head_job;
    logic    push;
    logic    queue_full;
    logic    pop;
    logic    head_valid;

    // Pack the incoming words into one vertex
    always_comb
    begin
        in_vtx.pos_x = pos_x;
        in_vtx.pos_y = pos_y;
        in_vtx.color = color_word;
        in_vtx.tex_u = tex_u;
        in_vtx.tex_v = tex_v;
    end

    // Front end: classify each vertex into a hold, pass or emit job, or drop it
    pta_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_vtx         (in_vtx),
        .primitive_kind (primitive_kind),
        .first_of_draw  (first_of_draw),
        .push           (push),
        .push_job       (push_job),
        .queue_full     (queue_full)
    );

    // Jobs stay in order, so holds always land before the emits that read them
    pta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back end: held vertices and the emit sequencer
    pta_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_vtx    (out_vtx),
        .out_last   (last_of_run)
    );

    assign out_pos_x = out_vtx.pos_x;
    assign out_pos_y = out_vtx.pos_y;
    assign out_color = out_vtx.color;
    assign out_tex_u = out_vtx.tex_u;
    assign out_tex_v = out_vtx.tex_v;

endmodule

[verif/tb_primitive_to_triangle_assembler.sv]
// Self-checking testbench for primitive_to_triangle_assembler: directed table, then random draws.
// Transactions are checked against an in-bench triangle-list predictor and typed directed rows.
// Depends on pta_pkg and the assembler RTL only.
`timescale 1ns / 1ps

module tb_primitive_to_triangle_assembler;

    import pta_pkg::*;

    // Kinds the block drops; the package only names the ones it assembles
    localparam logic [KIND_W-1:0] KIND_POINTS     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LINES      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LINE_STRIP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED     = 3'd7;

    // How a directed row gets its expectation
    localparam int ROW_PREDICTED = -1;  // from the predictor
    localparam int ROW_DROPS     = 0;   // typed: no output vertex
    localparam int ROW_ECHOES    = 1;   // typed: the vertex itself, marked last

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 380;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES  = 20;

    typedef struct {
        vertex_t         vtx;
        logic [KIND_W-1:0] kind;
        logic            first;
        int              typed_n;
    } stim_row_t;

    // One expected output transaction
    typedef struct {
        vertex_t vtx;
        logic    last;
    } tri_vertex_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [31:0] pos_x          = '0;
    logic [31:0] pos_y          = '0;
    logic [31:0] color_word     = '0;
    logic [31:0] tex_u          = '0;
    logic [31:0] tex_v          = '0;
    logic [2:0]  primitive_kind = '0;
    logic        first_of_draw  = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [31:0] out_pos_x;
    logic [31:0] out_pos_y;
    logic [31:0] out_color;
    logic [31:0] out_tex_u;
    logic [31:0] out_tex_v;
    logic        last_of_run;

    primitive_to_triangle_assembler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .color_word     (color_word),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .primitive_kind (primitive_kind),
        .first_of_draw  (first_of_draw),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_pos_x      (out_pos_x),
        .out_pos_y      (out_pos_y),
        .out_color      (out_color),
        .out_tex_u      (out_tex_u),
        .out_tex_v      (out_tex_v),
        .last_of_run    (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Triangle-list predictor: its own copy of the held vertices, the
    // position inside the draw and the latched kind. run_q collects the
    // vertices one input transaction causes.
    // ------------------------------------------------------------------
    vertex_t           held_vtx [3];
    logic [POS_W-1:0]  asm_pos  = '0;
    logic [KIND_W-1:0] asm_kind = '0;
    tri_vertex_t       run_q [$];
    tri_vertex_t       tri_list_q [$];   // expected output transactions, oldest first
    int                mismatch_count = 0;

    function automatic void emit_vertex(vertex_t v);
        tri_vertex_t e;
        e.vtx  = v;
        e.last = 1'b0;
        run_q.push_back(e);
    endfunction

    function automatic void assemble_vertex(vertex_t v, logic [KIND_W-1:0] kind, logic first);
        run_q.delete();
        // kind is only latched at the start of a draw
        if (first)
        begin
            asm_pos  = '0;
            asm_kind = kind;
        end
        case (asm_kind)
            KIND_TRIANGLES:
                emit_vertex(v);
            KIND_STRIP, KIND_FAN:
            begin
                if (asm_pos < SLOT_2)
                begin
                    held_vtx[asm_pos] = v;
                    asm_pos = asm_pos + 1'b1;
                end
                else
                begin
                    emit_vertex(held_vtx[SLOT_0]);
                    emit_vertex(held_vtx[SLOT_1]);
                    emit_vertex(v);
                    // strip slides its window; fan keeps the center in slot 0
                    if (asm_kind == KIND_STRIP)
                        held_vtx[SLOT_0] = held_vtx[SLOT_1];
                    held_vtx[SLOT_1] = v;
                end
            end
            KIND_QUADS:
            begin
                if (asm_pos < 2'd3)
                begin
                    held_vtx[asm_pos] = v;
                    asm_pos = asm_pos + 1'b1;
                end
                else
                begin
                    emit_vertex(held_vtx[SLOT_0]);
                    emit_vertex(held_vtx[SLOT_1]);
                    emit_vertex(held_vtx[SLOT_2]);
                    emit_vertex(held_vtx[SLOT_1]);
                    emit_vertex(held_vtx[SLOT_2]);
                    emit_vertex(v);
                    asm_pos = '0;
                end
            end
            default:
                ;  // points, lines, line strips, unused kind, nothing latched yet
        endcase
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic vertex_t pattern_vtx(logic [31:0] base);
        vertex_t v;
        v.pos_x = base;
        v.pos_y = base + 32'd1;
        v.color = ~base;
        v.tex_u = base ^ 32'hA5A5_A5A5;
        v.tex_v = {base[15:0], base[31:16]};
        return v;
    endfunction

    function automatic stim_row_t mk_row(vertex_t v, logic [KIND_W-1:0] kind, logic first,
                                         int typed_n);
        stim_row_t r;
        r.vtx     = v;
        r.kind    = kind;
        r.first   = first;
        r.typed_n = typed_n;
        return r;
    endfunction

    // Random word with the all-zero and all-one extremes favored
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic vertex_t random_vtx();
        vertex_t v;
        v.pos_x = rand_word();
        v.pos_y = rand_word();
        v.color = rand_word();
        v.tex_u = rand_word();
        v.tex_v = rand_word();
        return v;
    endfunction

    // Present one vertex at the falling edge, hold it until the rising edge
    // that takes the transaction, then record what it should cause.
    task automatic drive_vertex(stim_row_t r);
        tri_vertex_t e;
        @(negedge clk);
        in_valid       <= 1'b1;
        pos_x          <= r.vtx.pos_x;
        pos_y          <= r.vtx.pos_y;
        color_word     <= r.vtx.color;
        tex_u          <= r.vtx.tex_u;
        tex_v          <= r.vtx.tex_v;
        primitive_kind <= r.kind;
        first_of_draw  <= r.first;
        do
            @(posedge clk);
        while (!in_ready);
        assemble_vertex(r.vtx, r.kind, r.first);
        if (r.typed_n == ROW_PREDICTED)
        begin
            foreach (run_q[i])
                tri_list_q.push_back(run_q[i]);
        end
        else if (r.typed_n == ROW_ECHOES)
        begin
            e.vtx  = r.vtx;
            e.last = 1'b1;
            tri_list_q.push_back(e);
        end
    endtask

    task automatic rest(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Sender holds off until every expected vertex has come out
    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tri_list_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t ns  %s: expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Output checker: every output transaction against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tri_vertex_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tri_list_q.size() == 0)
                report_mismatch("unexpected output vertex, x word", '0, out_pos_x);
            else
            begin
                want = tri_list_q.pop_front();
                if (out_pos_x !== want.vtx.pos_x)
                    report_mismatch("out_pos_x", want.vtx.pos_x, out_pos_x);
                if (out_pos_y !== want.vtx.pos_y)
                    report_mismatch("out_pos_y", want.vtx.pos_y, out_pos_y);
                if (out_color !== want.vtx.color)
                    report_mismatch("out_color", want.vtx.color, out_color);
                if (out_tex_u !== want.vtx.tex_u)
                    report_mismatch("out_tex_u", want.vtx.tex_u, out_tex_u);
                if (out_tex_v !== want.vtx.tex_v)
                    report_mismatch("out_tex_v", want.vtx.tex_v, out_tex_v);
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", {31'd0, want.last}, {31'd0, last_of_run});
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: its own pattern, cycling through four styles in
    // turn - always ready, mostly ready, a fixed duty cycle, mostly stalled.
    // ------------------------------------------------------------------
    int rx_cycle = 0;

    always @(negedge clk)
    begin
        case ((rx_cycle / 97) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ((rx_cycle % 7) < 3);
            default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
        rx_cycle <= rx_cycle + 1;
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without a transaction on either channel.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("primitive_to_triangle_assembler: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    stim_row_t directed_tab [DIRECTED_ROWS];

    initial
    begin
        stim_row_t         row;
        logic [KIND_W-1:0] draw_kind;
        int                draw_len;
        int                live_items;
        int                burst_left;
        bit                no_gaps;

        // Directed table. Typed rows only where the answer is obvious:
        // drops, and triangle vertices passing straight through.
        // vertex before any draw: nothing latched after reset, dropped
        directed_tab[0]  = mk_row(pattern_vtx(32'h0000_0100), KIND_TRIANGLES, 1'b0, ROW_DROPS);
        // dropped kinds
        directed_tab[1]  = mk_row(pattern_vtx(32'h0000_0200), KIND_POINTS, 1'b1, ROW_DROPS);
        directed_tab[2]  = mk_row(pattern_vtx(32'h0000_0300), KIND_LINES, 1'b1, ROW_DROPS);
        directed_tab[3]  = mk_row(pattern_vtx(32'h0000_0400), KIND_LINE_STRIP, 1'b1, ROW_DROPS);
        directed_tab[4]  = mk_row(pattern_vtx(32'h0000_0500), KIND_UNUSED, 1'b1, ROW_DROPS);
        // triangles at the word extremes; kind on later vertices is ignored
        directed_tab[5]  = mk_row(vertex_t'('1), KIND_TRIANGLES, 1'b1, ROW_ECHOES);
        directed_tab[6]  = mk_row(vertex_t'('0), KIND_POINTS, 1'b0, ROW_ECHOES);
        directed_tab[7]  = mk_row(vertex_t'({5{32'h5555_5555}}), KIND_UNUSED, 1'b0, ROW_ECHOES);
        directed_tab[8]  = mk_row(vertex_t'({5{32'hAAAA_AAAA}}), KIND_QUADS, 1'b0, ROW_ECHOES);
        // strip: two held, then a triangle per vertex with a sliding window
        directed_tab[9]  = mk_row(pattern_vtx(32'h1000_0001), KIND_STRIP, 1'b1, ROW_DROPS);
        directed_tab[10] = mk_row(pattern_vtx(32'h1000_0002), KIND_FAN, 1'b0, ROW_DROPS);
        directed_tab[11] = mk_row(pattern_vtx(32'h1000_0003), KIND_STRIP, 1'b0, ROW_PREDICTED);
        directed_tab[12] = mk_row(pattern_vtx(32'h1000_0004), KIND_STRIP, 1'b0, ROW_PREDICTED);
        // fan: center stays, previous vertex moves
        directed_tab[13] = mk_row(pattern_vtx(32'h2000_0001), KIND_FAN, 1'b1, ROW_DROPS);
        directed_tab[14] = mk_row(pattern_vtx(32'h2000_0002), KIND_FAN, 1'b0, ROW_DROPS);
        directed_tab[15] = mk_row(pattern_vtx(32'h2000_0003), KIND_FAN, 1'b0, ROW_PREDICTED);
        directed_tab[16] = mk_row(pattern_vtx(32'h2000_0004), KIND_FAN, 1'b0, ROW_PREDICTED);
        // quad: three held, fourth emits six
        directed_tab[17] = mk_row(pattern_vtx(32'h3000_0001), KIND_QUADS, 1'b1, ROW_DROPS);
        directed_tab[18] = mk_row(pattern_vtx(32'h3000_0002), KIND_QUADS, 1'b0, ROW_DROPS);
        directed_tab[19] = mk_row(pattern_vtx(32'h3000_0003), KIND_QUADS, 1'b0, ROW_DROPS);
        directed_tab[20] = mk_row(pattern_vtx(32'h3000_0004), KIND_QUADS, 1'b0, ROW_PREDICTED);
        // incomplete second quad, cut off by a new triangle draw
        directed_tab[21] = mk_row(pattern_vtx(32'h3000_0005), KIND_QUADS, 1'b0, ROW_DROPS);
        directed_tab[22] = mk_row(pattern_vtx(32'h3000_0006), KIND_QUADS, 1'b0, ROW_DROPS);
        directed_tab[23] = mk_row(pattern_vtx(32'h4000_0001), KIND_TRIANGLES, 1'b1, ROW_ECHOES);
        // short strip, cut off by the first random draw
        directed_tab[24] = mk_row(pattern_vtx(32'h5000_0001), KIND_STRIP, 1'b1, ROW_DROPS);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_tab[i])
        begin
            if ($urandom_range(0, 2) == 0)
                rest($urandom_range(1, 3));
            drive_vertex(directed_tab[i]);
        end
        // hold off until the pipeline is empty at least once
        drain_outputs();

        // Random draws: mostly assembling kinds with well-formed lengths,
        // some dropped kinds and cut-off quads as noise. Only vertices of
        // assembling draws count toward the total.
        live_items = 0;
        burst_left = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       draw_kind = KIND_POINTS;
                    1:       draw_kind = KIND_LINES;
                    2:       draw_kind = KIND_LINE_STRIP;
                    default: draw_kind = KIND_UNUSED;
                endcase
                draw_len = $urandom_range(1, 4);
            end
            else
            begin
                draw_kind = 3'($urandom_range(KIND_TRIANGLES, KIND_QUADS));
                case (draw_kind)
                    KIND_QUADS:
                    begin
                        draw_len = 4 * $urandom_range(1, 3);
                        if ($urandom_range(0, 6) == 0)
                            draw_len = draw_len + $urandom_range(1, 3);
                    end
                    KIND_TRIANGLES: draw_len = $urandom_range(1, 8);
                    default:        draw_len = $urandom_range(1, 10);
                endcase
            end

            for (int i = 0; i < draw_len; i++)
            begin
                // back-to-back stretch in the middle of the run
                no_gaps = (live_items >= 150) && (live_items < 220);
                if (burst_left == 0)
                begin
                    if (!no_gaps)
                        rest($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 20);
                end
                burst_left--;

                row.vtx     = random_vtx();
                row.first   = (i == 0);
                // kind on non-first vertices is random and must be ignored
                row.kind    = row.first ? draw_kind : 3'($urandom_range(0, 7));
                row.typed_n = ROW_PREDICTED;
                drive_vertex(row);
                if (draw_kind >= KIND_TRIANGLES && draw_kind <= KIND_QUADS)
                    live_items++;
            end

            if ($urandom_range(0, 15) == 0)
                drain_outputs();
        end

        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("primitive_to_triangle_assembler: match");
        else
            $display("primitive_to_triangle_assembler: mismatch");
        $finish;
    end

endmodule

[primitive_to_triangle_assembler.f]
hw/rtl/pta_pkg.sv
hw/rtl/pta_front.sv
hw/rtl/pta_queue.sv
hw/rtl/pta_back.sv
hw/rtl/primitive_to_triangle_assembler.sv
verif/tb_primitive_to_triangle_assembler.sv
